### rtl/prq_pkg.sv
// shared types, constants and codes of the priority ready queue
package prq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int TASK_COUNT  = 32;
  localparam int TASK_W      = $clog2(TASK_COUNT);
  localparam int PRIO_W      = 8;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_DISPATCH = 2'd1,
    CMD_CHECK    = 2'd2
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] prio;
    logic [PRIO_W-1:0] disp;
  } entry_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   ent;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              new_head;
    logic              preempt;
    logic              task_valid;
    logic [TASK_W-1:0] next_task;
    logic [PRIO_W-1:0] next_priority;
  } result_t;

endpackage

### rtl/prq_if.sv
// request and result channel interfaces of the priority ready queue
interface prq_in_if;
  import prq_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [TASK_W-1:0] task_id;
  logic [PRIO_W-1:0] priority_req;
  logic [PRIO_W-1:0] dispatch_priority;
  logic [PRIO_W-1:0] running_priority;
  logic              allow_preempt;

  modport source (output valid, command, task_id, priority_req, dispatch_priority,
                  running_priority, allow_preempt, input ready);
  modport sink (input valid, command, task_id, priority_req, dispatch_priority,
                running_priority, allow_preempt, output ready);
endinterface

interface prq_out_if;
  import prq_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic              new_head;
  logic              preempt;
  logic              task_valid;
  logic [TASK_W-1:0] next_task;
  logic [PRIO_W-1:0] next_priority;

  modport source (output valid, status, new_head, preempt, task_valid, next_task,
                  next_priority, input ready);
  modport sink (input valid, status, new_head, preempt, task_valid, next_task,
                next_priority, output ready);
endinterface

### rtl/prq_cell.sv
// one queue slot: holds an entry, shifts right on insert and left on pop
module prq_cell (
  input  logic              clk,
  input  prq_pkg::cell_ctl_t ctl,
  input  logic              occ,
  input  logic              left_stay,
  input  prq_pkg::entry_t   left_ent,
  input  prq_pkg::entry_t   right_ent,
  output prq_pkg::entry_t   ent,
  output logic              stay
);
  import prq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // occupied slot of equal or higher priority keeps its entry on insert
  assign stay = occ && (ent_r.prio >= ctl.ent.prio);
  assign ent  = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    case (ctl.op)
      OP_INSERT: begin
        if (!stay) begin
          ent_nxt = left_stay ? ctl.ent : left_ent;
        end
      end
      OP_POP: begin
        ent_nxt = right_ent;
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end
endmodule

### rtl/priority_ready_queue_scheduler_core.sv
// Priority ready queue: a row of slots sorted by priority, FIFO among equals.
// in_req carries one command per request: insert a task, dispatch the head,
// or check the head against the running priority and dispatch it if it
// outranks it. out_rsp returns exactly one result per request.
// Slot 0 is the head; on insert every slot compares its priority with the new
// one in parallel and the slots behind the insertion point shift one place
// back; on removal all slots shift one place forward.
// The result is registered and shows on out_rsp in the cycle after the
// request is taken. Throughput: one request per cycle while results are taken;
// the compare across all slots and the shift happen in the accepting cycle.
// in_req.ready is high while the result register is empty or being emptied,
// so a stalled receiver holds off new requests after one pending result.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; slot contents past the fill count are never looked at.
module priority_ready_queue_scheduler_core (
  input logic  clk,
  input logic  rst_n,
  prq_in_if.sink    in_req,
  prq_out_if.source out_rsp
);
  import prq_pkg::*;

  cell_ctl_t           ctl;
  entry_t              ent_w  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] stay_w;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  result_t             res_r, res_nxt;
  logic                accept;
  logic                full, empty;
  entry_t              head;

  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign accept       = in_req.valid && in_req.ready;
  assign full         = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty        = (count_r == '0);
  assign head         = ent_w[0];

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      entry_t left_ent;
      entry_t right_ent;
      logic   left_stay;
      logic   occ;
      if (gi == 0) begin : g_first
        assign left_ent  = ctl.ent;
        assign left_stay = 1'b1;
      end else begin : g_mid
        assign left_ent  = ent_w[gi-1];
        assign left_stay = stay_w[gi-1];
      end
      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign right_ent = ent_w[gi];
      end else begin : g_inner
        assign right_ent = ent_w[gi+1];
      end
      assign occ = (count_r > CNT_W'(gi));
      prq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occ       (occ),
        .left_stay (left_stay),
        .left_ent  (left_ent),
        .right_ent (right_ent),
        .ent       (ent_w[gi]),
        .stay      (stay_w[gi])
      );
    end
  endgenerate

  always_comb begin
    ctl.op          = OP_HOLD;
    ctl.ent.task_id = in_req.task_id;
    ctl.ent.prio    = in_req.priority_req;
    ctl.ent.disp    = in_req.dispatch_priority;
    count_nxt       = count_r;
    res_nxt         = '0;
    case (cmd_e_t'(in_req.command))
      CMD_INSERT: begin
        if (full) begin
          res_nxt.status = ST_FULL;
        end else begin
          ctl.op           = OP_INSERT;
          count_nxt        = count_r + CNT_W'(1);
          res_nxt.new_head = !stay_w[0];
          res_nxt.preempt  = !stay_w[0] && in_req.allow_preempt &&
                             (in_req.running_priority < in_req.priority_req);
        end
      end
      CMD_DISPATCH: begin
        if (empty) begin
          res_nxt.status = ST_EMPTY;
        end else begin
          ctl.op = OP_POP;
        end
      end
      CMD_CHECK: begin
        if (!empty && (head.prio > in_req.running_priority)) begin
          ctl.op          = OP_POP;
          res_nxt.preempt = 1'b1;
        end
      end
      default: begin
        ctl.op = OP_HOLD;
      end
    endcase
    if (ctl.op == OP_POP) begin
      count_nxt             = count_r - CNT_W'(1);
      res_nxt.task_valid    = 1'b1;
      res_nxt.next_task     = head.task_id;
      res_nxt.next_priority = (head.prio < head.disp) ? head.disp : head.prio;
    end
    if (!accept) begin
      ctl.op    = OP_HOLD;
      count_nxt = count_r;
      res_nxt   = res_r;
    end
    out_valid_nxt = accept || (out_valid_r && !out_rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = res_r.status;
  assign out_rsp.new_head      = res_r.new_head;
  assign out_rsp.preempt       = res_r.preempt;
  assign out_rsp.task_valid    = res_r.task_valid;
  assign out_rsp.next_task     = res_r.next_task;
  assign out_rsp.next_priority = res_r.next_priority;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (ent_w[1].prio <= ent_w[0].prio))
    else $error("queue head not highest priority");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req.command == CMD_INSERT) && !full)
      |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow queue");

  a_task_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.task_valid) |-> (res_r.status == ST_OK && !res_r.new_head))
    else $error("dispatched task with bad status");
`endif
endmodule
